// ----- rtl/itdt_pkg.sv -----
// Shared types and constants for the integer to decimal text unit.
// No dependencies; the front end, queue, converter and top module refer to this package.
package itdt_pkg;

    localparam int unsigned NUM_DIGITS = 10;
    localparam logic [7:0]  CHAR_ZERO  = 8'd48;
    localparam logic [7:0]  CHAR_MINUS = 8'd45;

    // Digit index 0..9 (power of ten of the digit being produced)
    typedef logic [3:0] t_digit_idx;

    // Multiples j * 10^k, j and k in 0..9; 9 * 10^9 needs 34 bits
    typedef logic [NUM_DIGITS-1:0][NUM_DIGITS-1:0][33:0] t_mult_tab;

    // One classified number waiting for conversion
    typedef struct packed {
        logic        neg;
        t_digit_idx  top;   // index of the leading digit
        logic [31:0] mag;
    } t_entry;

    function automatic t_mult_tab build_mult_tab();
        t_mult_tab   tab;
        logic [33:0] pw;
        pw = 34'd1;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            for (int j = 0; j < NUM_DIGITS; j++) begin
                tab[k][j] = 34'(pw * j);
            end
            pw = 34'(pw * 10);
        end
        return tab;
    endfunction

    localparam t_mult_tab MULT_TAB = build_mult_tab();

endpackage

// ----- rtl/itdt_in_if.sv -----
// Input channel of the integer to decimal text unit: valid/ready plus value.
// Standalone; no package needed.
interface itdt_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/itdt_out_if.sv -----
// Output channel of the integer to decimal text unit: one character per transfer.
// Standalone; no package needed.
interface itdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- rtl/itdt_front.sv -----
// Front end: accepts a number, forms sign and magnitude, counts its digits.
// Depends on itdt_pkg and itdt_in_if.
module itdt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    itdt_in_if.sink          i_in,
    output logic             o_push,
    output itdt_pkg::t_entry o_entry,
    input  logic             i_push_ready
);

    logic        r_valid;
    logic        r_neg;
    logic [31:0] r_mag;
    itdt_pkg::t_digit_idx w_top;

    assign i_in.ready = !r_valid || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_neg <= i_in.value[31];
            r_mag <= i_in.value[31] ? 32'd0 - $unsigned(i_in.value) : $unsigned(i_in.value);
        end
    end

    // Leading digit index = number of powers of ten (10..10^9) not above the magnitude
    always_comb begin
        w_top = '0;
        for (int k = 1; k < itdt_pkg::NUM_DIGITS; k++) begin
            if ({2'b00, r_mag} >= itdt_pkg::MULT_TAB[k][1]) begin
                w_top = w_top + 4'd1;
            end
        end
    end

    assign o_push        = r_valid;
    assign o_entry.neg   = r_neg;
    assign o_entry.top   = w_top;
    assign o_entry.mag   = r_mag;

endmodule

// ----- rtl/itdt_queue.sv -----
// Two-entry queue between front end and converter.
// Depends on itdt_pkg for the entry type.
module itdt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  itdt_pkg::t_entry i_entry,
    output logic             o_push_ready,
    output logic             o_valid,
    output itdt_pkg::t_entry o_entry,
    input  logic             i_pop
);

    itdt_pkg::t_entry r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_do_push;
    logic       w_do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_entry      = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && o_push_ready;
    assign w_do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(w_do_push) - 2'(w_do_pop);
        end
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

// ----- rtl/itdt_back.sv -----
// Converter: emits sign and decimal digits, most significant first, one per cycle while the output accepts.
// Depends on itdt_pkg and itdt_out_if.
module itdt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  itdt_pkg::t_entry i_entry,
    output logic             o_pop,
    itdt_out_if.source       o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    t_state               r_state;
    logic [31:0]          r_rem;
    itdt_pkg::t_digit_idx r_k;
    logic                 r_out_valid;
    logic [7:0]           r_char;
    logic                 r_last;

    logic                 w_out_free;
    logic [3:0]           w_digit;
    logic [31:0]          w_rem_next;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == ST_IDLE) && i_valid;

    // Digit = largest j with j * 10^k not above the remainder
    always_comb begin
        w_digit = '0;
        for (int j = 1; j < itdt_pkg::NUM_DIGITS; j++) begin
            if ({2'b00, r_rem} >= itdt_pkg::MULT_TAB[r_k][j]) begin
                w_digit = 4'(j);
            end
        end
        w_rem_next = r_rem - itdt_pkg::MULT_TAB[r_k][w_digit][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Load a character whenever the output register frees up in an emitting state
            if (w_out_free) begin
                r_out_valid <= (r_state == ST_SIGN) || (r_state == ST_DIGIT);
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_rem   <= i_entry.mag;
                        r_k     <= i_entry.top;
                        r_state <= i_entry.neg ? ST_SIGN : ST_DIGIT;
                    end
                end
                ST_SIGN: begin
                    if (w_out_free) begin
                        r_char      <= itdt_pkg::CHAR_MINUS;
                        r_last      <= 1'b0;
                        r_state     <= ST_DIGIT;
                    end
                end
                ST_DIGIT: begin
                    if (w_out_free) begin
                        r_char      <= itdt_pkg::CHAR_ZERO + {4'd0, w_digit};
                        r_last      <= (r_k == '0);
                        r_rem       <= w_rem_next;
                        r_k         <= r_k - 4'd1;
                        if (r_k == '0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_char != itdt_pkg::CHAR_MINUS)
        else $error("sign marked as last character");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_char == itdt_pkg::CHAR_MINUS ||
                        (r_char >= itdt_pkg::CHAR_ZERO && r_char <= itdt_pkg::CHAR_ZERO + 8'd9))
        else $error("character outside sign and digits");

    a_digit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIGIT |-> r_k <= 4'd9)
        else $error("digit index beyond 10^9");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIGIT && r_k != 4'd9 |->
            {2'b00, r_rem} < itdt_pkg::MULT_TAB[r_k + 4'd1][1])
        else $error("remainder too large for digit position");

endmodule

// ----- rtl/integer_to_decimal_text_unit.sv -----
// Signed 32-bit integer to ASCII decimal text, one character per output transfer.
// Path: the front end registers the number, the queue stores it, the converter loads it, then registers each character.
// The converter emits one digit per cycle while the output accepts, and loads the next number
//   only after it has emitted the last digit of the current one.
// A two-entry queue lets the front end take up to three numbers ahead of the output.
// Reset: synchronous, active low; clears all control state, no clearing pass.
module integer_to_decimal_text_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itdt_in_if.sink     i_in,
    itdt_out_if.source  o_out
);

    logic             w_push;
    logic             w_push_ready;
    itdt_pkg::t_entry w_push_entry;
    logic             w_q_valid;
    logic             w_pop;
    itdt_pkg::t_entry w_q_entry;

    itdt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push       (w_push),
        .o_entry      (w_push_entry),
        .i_push_ready (w_push_ready)
    );

    itdt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_entry      (w_push_entry),
        .o_push_ready (w_push_ready),
        .o_valid      (w_q_valid),
        .o_entry      (w_q_entry),
        .i_pop        (w_pop)
    );

    itdt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_entry (w_q_entry),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for integer_to_decimal_text_unit: drives signed integers, predicts
// their ASCII text and checks every character. Needs itdt_pkg, itdt_in_if, itdt_out_if.
module tb_top;

    localparam int unsigned DECIMAL_BASE  = 10;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STUCK_LIMIT   = 3000;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned PHASE_ITEMS   = 38;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_text_char;

    logic clk;
    logic rst_n;

    itdt_in_if  in_ch ();
    itdt_out_if out_ch ();

    integer_to_decimal_text_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    logic [31:0]  numbers_pending[$];
    t_text_char   text_expect[$];
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  hold_requests;
    int unsigned  hold_served;
    int unsigned  hold_left;
    int unsigned  stuck_cycles;
    bit           failed;

    // Expected characters of one number, sign first, most significant digit next
    function automatic void push_decimal_text(input logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  digit_chars[10];
        int          n;
        mag = raw[31] ? (~raw + 32'd1) : raw;
        n = 0;
        do begin
            digit_chars[n] = itdt_pkg::CHAR_ZERO + 8'(mag % DECIMAL_BASE);
            n++;
            mag = mag / DECIMAL_BASE;
        end while (mag != 0);
        if (raw[31]) begin
            text_expect.push_back('{itdt_pkg::CHAR_MINUS, 1'b0});
        end
        for (int k = n - 1; k >= 0; k--) begin
            text_expect.push_back('{digit_chars[k], (k == 0)});
        end
    endfunction

    // Mostly magnitudes of up to 9 digits with random sign, some powers of ten or one less, some full-range words
    function automatic logic [31:0] pick_number();
        int unsigned kind;
        int unsigned digits;
        logic [31:0] scale;
        logic [31:0] mag;
        kind = $urandom_range(9);
        if (kind < 3) begin
            return $urandom;
        end
        digits = $urandom_range(1, 9);
        scale = 32'd1;
        repeat (digits) scale = scale * DECIMAL_BASE;
        if (kind == 3) begin
            mag = scale - 32'($urandom_range(1));
        end else begin
            mag = $urandom % scale;
        end
        return $urandom_range(1) ? (~mag + 32'd1) : mag;
    endfunction

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: offer the next pending number, predict its text on transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                push_decimal_text(in_ch.value);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (numbers_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.value <= numbers_pending.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each character transfer and pace ready
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_served <= 0;
            hold_left <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (text_expect.size() == 0) begin
                    $display("%0t: unexpected character %0d last %0b, nothing expected",
                             $time, out_ch.character, out_ch.last);
                    failed = 1'b1;
                end else begin
                    if (out_ch.character !== text_expect[0].character
                            || out_ch.last !== text_expect[0].last) begin
                        $display("%0t: mismatch, expected char %0d last %0b, got char %0d last %0b",
                                 $time, text_expect[0].character, text_expect[0].last,
                                 out_ch.character, out_ch.last);
                        failed = 1'b1;
                    end
                    void'(text_expect.pop_front());
                end
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_served != hold_requests) begin
                // long hold-off: let the unit fill up and stall its input
                hold_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (numbers_pending.size() != 0 || in_ch.valid || text_expect.size() != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        failed = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero, single digits, decade edges, both extremes, alternating bits
        numbers_pending.push_back(32'd0);
        numbers_pending.push_back(32'd1);
        numbers_pending.push_back(32'hFFFF_FFFF);
        numbers_pending.push_back(32'd9);
        numbers_pending.push_back(32'd10);
        numbers_pending.push_back(-32'sd10);
        numbers_pending.push_back(-32'sd7);
        numbers_pending.push_back(32'd99);
        numbers_pending.push_back(32'd100);
        numbers_pending.push_back(32'h7FFF_FFFF);
        numbers_pending.push_back(32'h8000_0000);
        numbers_pending.push_back(32'h8000_0001);
        numbers_pending.push_back(32'd999_999_999);
        numbers_pending.push_back(32'd1_000_000_000);
        numbers_pending.push_back(-32'sd999_999_999);
        numbers_pending.push_back(-32'sd1_000_000_000);
        numbers_pending.push_back(32'd12345);
        numbers_pending.push_back(32'h5555_5555);
        numbers_pending.push_back(32'hAAAA_AAAA);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_requests++;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct = 15;
                    recv_stall_pct = 15;
                end
            endcase
            repeat (PHASE_ITEMS) numbers_pending.push_back(pick_number());
            // hold the sender until every character of this phase has come out
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && text_expect.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
